[hw/rtl/ndef_rhp_pkg.sv]
// shared types and constants for the ndef record header parser
// holds parse phases, end reason codes, header bit positions and the result struct
// no dependencies
package ndef_rhp_pkg;

  // parameter defaults
  localparam int DEF_MAX_RECORDS = 8;
  localparam int DEF_TYPE_KEEP   = 8;

  // record header bits
  localparam int    HDR_ME_BIT = 6;
  localparam int    HDR_SR_BIT = 4;
  localparam int    HDR_IL_BIT = 3;
  localparam int    TYPE_SLOTS = 8;

  // result tdata packing, lowest field first
  localparam int    RES_BITS = 156;
  localparam int    TDATA_W  = 160;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE_LEN,
    PH_PLEN,
    PH_ID_LEN,
    PH_TYPE,
    PH_ID,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    END_ME       = 2'd0,
    END_BOUNDARY = 2'd1,
    END_CUT      = 2'd2,
    END_LIMIT    = 2'd3
  } end_reason_t;

  typedef struct packed {
    logic        record_valid;
    logic [2:0]  record_index;
    logic [7:0]  header_flags;
    logic [2:0]  type_name_format;
    logic [7:0]  type_length;
    logic [63:0] type_head;
    logic [31:0] payload_length;
    logic [31:0] payload_offset;
    logic        message_done;
    end_reason_t end_reason;
    logic [3:0]  record_total;
  } rhp_result_t;

endpackage

[hw/rtl/ndef_rhp_core.sv]
// parse state of the ndef record header parser and its per-byte update
// one registered byte in, one optional result out, state committed on step
// depends on ndef_rhp_pkg
module ndef_rhp_core #(
  parameter int MAX_RECORDS = ndef_rhp_pkg::DEF_MAX_RECORDS,
  parameter int TYPE_KEEP   = ndef_rhp_pkg::DEF_TYPE_KEEP
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output ndef_rhp_pkg::rhp_result_t res,
  output logic                      res_fire
);
  import ndef_rhp_pkg::*;

  localparam int CW = $clog2(MAX_RECORDS + 1);

  // control state
  phase_t        parse_phase, parse_phase_next;
  logic [31:0]   byte_position, byte_position_next;
  logic [CW-1:0] records_done, records_done_next;
  logic          stopped, stopped_next;

  // held record fields
  logic [7:0]  held_header, held_header_next;
  logic [7:0]  held_type_length, held_type_length_next;
  logic [7:0]  held_id_length, held_id_length_next;
  logic [31:0] held_payload_length, held_payload_length_next;
  logic [31:0] field_countdown, field_countdown_next;
  logic [63:0] held_type_bytes, held_type_bytes_next;
  logic [31:0] held_payload_offset, held_payload_offset_next;

  logic          rec_complete;
  logic          msg_done;
  end_reason_t   reason;
  logic [CW-1:0] rec_idx;
  logic [7:0]    type_idx;
  logic [31:0]   cd_dec;
  logic          go_type, go_id, go_pay;

  // per-byte parse step
  always_comb begin
    parse_phase_next         = parse_phase;
    byte_position_next       = byte_position;
    records_done_next        = records_done;
    stopped_next             = stopped;
    held_header_next         = held_header;
    held_type_length_next    = held_type_length;
    held_id_length_next      = held_id_length;
    held_payload_length_next = held_payload_length;
    field_countdown_next     = field_countdown;
    held_type_bytes_next     = held_type_bytes;
    held_payload_offset_next = held_payload_offset;
    rec_complete             = 1'b0;
    msg_done                 = 1'b0;
    reason                   = END_ME;
    rec_idx                  = records_done;
    go_type                  = 1'b0;
    go_id                    = 1'b0;
    go_pay                   = 1'b0;
    cd_dec                   = field_countdown - 32'd1;
    type_idx                 = held_type_length - field_countdown[7:0];

    if (stopped) begin
      // skip bytes until the end of the message
      if (last_byte) begin
        parse_phase_next   = PH_HEADER;
        byte_position_next = '0;
        records_done_next  = '0;
        stopped_next       = 1'b0;
      end
    end else begin
      byte_position_next = byte_position + 32'd1;

      case (parse_phase)
        PH_HEADER: begin
          if (records_done >= CW'(MAX_RECORDS)) begin
            msg_done = 1'b1;
            reason   = END_LIMIT;
          end else begin
            held_header_next         = data_byte;
            held_type_length_next    = '0;
            held_id_length_next      = '0;
            held_payload_length_next = '0;
            held_type_bytes_next     = '0;
            held_payload_offset_next = '0;
            parse_phase_next         = PH_TYPE_LEN;
          end
        end
        PH_TYPE_LEN: begin
          held_type_length_next    = data_byte;
          held_payload_length_next = '0;
          field_countdown_next     = held_header[HDR_SR_BIT] ? 32'd1 : 32'd4;
          parse_phase_next         = PH_PLEN;
        end
        PH_PLEN: begin
          held_payload_length_next = {held_payload_length[23:0], data_byte};
          field_countdown_next     = cd_dec;
          if (cd_dec == '0) begin
            if (held_header[HDR_IL_BIT]) parse_phase_next = PH_ID_LEN;
            else go_type = 1'b1;
          end
        end
        PH_ID_LEN: begin
          held_id_length_next = data_byte;
          go_type             = 1'b1;
        end
        PH_TYPE: begin
          // keep the first type bytes in their lanes
          for (int k = 0; k < TYPE_SLOTS; k++) begin
            if (k < TYPE_KEEP && type_idx == 8'(k)) begin
              held_type_bytes_next[8*k +: 8] = data_byte;
            end
          end
          field_countdown_next = cd_dec;
          if (cd_dec == '0) go_id = 1'b1;
        end
        PH_ID: begin
          field_countdown_next = cd_dec;
          if (cd_dec == '0) go_pay = 1'b1;
        end
        PH_PAYLOAD: begin
          field_countdown_next = cd_dec;
          if (cd_dec == '0) begin
            parse_phase_next = PH_HEADER;
            rec_complete     = 1'b1;
          end
        end
        default: begin
          parse_phase_next = PH_HEADER;
        end
      endcase

      // skip empty type, id and payload fields
      if (go_type) begin
        if (held_type_length_next != '0) begin
          parse_phase_next     = PH_TYPE;
          field_countdown_next = 32'(held_type_length_next);
        end else begin
          go_id = 1'b1;
        end
      end
      if (go_id) begin
        if (held_id_length_next != '0) begin
          parse_phase_next     = PH_ID;
          field_countdown_next = 32'(held_id_length_next);
        end else begin
          go_pay = 1'b1;
        end
      end
      if (go_pay) begin
        held_payload_offset_next = byte_position_next;
        if (held_payload_length_next == '0) begin
          parse_phase_next = PH_HEADER;
          rec_complete     = 1'b1;
        end else begin
          parse_phase_next     = PH_PAYLOAD;
          field_countdown_next = held_payload_length_next;
        end
      end

      // end of message decision
      if (rec_complete) begin
        records_done_next = records_done + CW'(1);
        if (held_header[HDR_ME_BIT]) begin
          msg_done = 1'b1;
          reason   = END_ME;
        end
      end
      if (!msg_done && last_byte) begin
        msg_done = 1'b1;
        reason   = (parse_phase_next == PH_HEADER) ? END_BOUNDARY : END_CUT;
      end
    end
  end

  // result fields, zero where they do not apply
  always_comb begin
    res          = '0;
    res_fire     = !stopped && (rec_complete || msg_done);
    if (rec_complete) begin
      res.record_valid     = 1'b1;
      res.record_index     = 3'(rec_idx);
      res.header_flags     = held_header;
      res.type_name_format = held_header[2:0];
      res.type_length      = held_type_length_next;
      res.type_head        = held_type_bytes_next;
      res.payload_length   = held_payload_length_next;
      res.payload_offset   = held_payload_offset_next;
    end
    if (msg_done) begin
      res.message_done = 1'b1;
      res.end_reason   = reason;
      res.record_total = 4'(records_done_next);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      byte_position <= '0;
      records_done  <= '0;
      stopped       <= 1'b0;
    end else if (step) begin
      if (!stopped && last_byte) begin
        parse_phase   <= PH_HEADER;
        byte_position <= '0;
        records_done  <= '0;
        stopped       <= 1'b0;
      end else begin
        parse_phase   <= parse_phase_next;
        byte_position <= byte_position_next;
        records_done  <= records_done_next;
        stopped       <= stopped_next | msg_done;
      end
    end
  end

  // held record fields
  always_ff @(posedge clk) begin
    if (step) begin
      held_header         <= held_header_next;
      held_type_length    <= held_type_length_next;
      held_id_length      <= held_id_length_next;
      held_payload_length <= held_payload_length_next;
      field_countdown     <= field_countdown_next;
      held_type_bytes     <= held_type_bytes_next;
      held_payload_offset <= held_payload_offset_next;
    end
  end

  // record count never passes the limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    records_done <= CW'(MAX_RECORDS))
    else $error("record count beyond limit");

  // a byte marked last restarts the message
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> byte_position == '0 && records_done == '0 && !stopped)
    else $error("message did not restart after last byte");

  // a completed record always leaves the parser at a header boundary
  a_rec_boundary: assert property (@(posedge clk) disable iff (rst)
    step && res_fire && res.record_valid && !last_byte |=> parse_phase == PH_HEADER)
    else $error("record completed away from header boundary");

  // a stopped parser gives no result
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !res_fire)
    else $error("result while stopped");

endmodule

[hw/rtl/ndef_record_header_parser.sv]
// ndef record header parser: a byte reaches its result item via byte and result registers
// one byte per cycle unless m_axis_tready stalls; byte and result registers part the sides
// a result waiting on m_axis_tready stalls input only once the byte register is also full
// rst (synchronous) clears the parse state to a new message and empties both registers
// depends on ndef_rhp_pkg and ndef_rhp_core
module ndef_record_header_parser #(
  parameter int MAX_RECORDS = ndef_rhp_pkg::DEF_MAX_RECORDS,
  parameter int TYPE_KEEP   = ndef_rhp_pkg::DEF_TYPE_KEEP
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // data_byte
  input  logic                             s_axis_tlast,  // last_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // record_index, header_flags, type_name_format, type_length, type_head,
  // payload_length, payload_offset, end_reason, record_total, zero pad
  output logic [ndef_rhp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,  // record_valid
  output logic                             m_axis_tlast   // message_done
);
  import ndef_rhp_pkg::*;

  logic        in_vld;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  logic        out_vld;
  rhp_result_t out_res;
  rhp_result_t res;
  logic        res_fire;

  assign advance       = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  ndef_rhp_core #(
    .MAX_RECORDS (MAX_RECORDS),
    .TYPE_KEEP   (TYPE_KEEP)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res       (res),
    .res_fire  (res_fire)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && res_fire) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      out_res <= res;
    end
  end

  // output packing
  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_res.record_valid;
  assign m_axis_tlast  = out_res.message_done;
  assign m_axis_tdata  = {(TDATA_W - RES_BITS)'(0),
                          out_res.record_total,
                          out_res.end_reason,
                          out_res.payload_offset,
                          out_res.payload_length,
                          out_res.type_head,
                          out_res.type_length,
                          out_res.type_name_format,
                          out_res.header_flags,
                          out_res.record_index};

  // a held result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the core only steps on a held byte
  a_step_src: assert property (@(posedge clk) disable iff (rst)
    advance |-> in_vld)
    else $error("step without a byte");

  // every result describes a record or ends a message
  a_res_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
    else $error("empty result");

endmodule
